/* src/acar_pkg.sv */
// shared constants, types and helpers for the adc channel average / ratio block
// no dependencies; imported by acar_div and adc_channel_average_ratio

package acar_pkg;

    // sample and accumulator sizing
    localparam int SAMPLE_BITS = 12;
    localparam int COUNT_BITS  = 16;
    localparam int SUM_W       = SAMPLE_BITS + COUNT_BITS;

    // register and field widths
    localparam int CENTER_W = 12;
    localparam int SPAN_W   = 13;
    localparam int CHAN_W   = 3;
    localparam int OP_W     = 2;
    localparam int AXIS_W   = 2;
    localparam int RATIO_W  = 8;
    localparam int MV_W     = 13;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 13;

    // stream packing
    localparam int IN_BITS     = CHAN_W + SAMPLE_BITS;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = AXIS_W + RATIO_W + MV_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // slots
    localparam int NUM_SLOTS = 5;
    localparam int NUM_AXES  = 4;
    localparam int SLOT_W    = 3;
    localparam logic [SLOT_W-1:0] BATT_SLOT = 3'd4;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // scaling constants and multiplier sizing
    localparam int MULK_W  = 13;
    localparam int MULA_W  = SUM_W + 1;
    localparam int MULB_W  = (COUNT_BITS + 1 > MULK_W + 1) ? COUNT_BITS + 1 : MULK_W + 1;
    localparam int PROD_W  = MULA_W + MULB_W;
    localparam int RATIO_SCALE = 200;
    localparam int MV_SCALE    = 5000;
    localparam int BATT_DIV    = 4098;

    // divider sizing
    localparam int NUM_W  = SUM_W + MULK_W;
    localparam int DEN_W  = COUNT_BITS + MULK_W;
    localparam int Q_W    = MV_W;
    localparam int DVS_W  = DEN_W + Q_W;
    localparam int CMP_W  = (NUM_W > DVS_W) ? NUM_W : DVS_W;
    localparam int QCNT_W = $clog2(Q_W + 1);
    localparam logic [QCNT_W-1:0] JOY_QBITS  = QCNT_W'(7);
    localparam logic [QCNT_W-1:0] BATT_QBITS = QCNT_W'(Q_W);

    // result limits
    localparam logic [RATIO_W-2:0] RATIO_MAX = 7'd100;
    localparam logic [MV_W-1:0]    MV_MAX    = {MV_W{1'b1}};

    // op codes
    localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
    localparam logic [OP_W-1:0] OP_JOY    = 2'd1;
    localparam logic [OP_W-1:0] OP_BATT   = 2'd2;

    // result kinds
    localparam logic KIND_JOY  = 1'b0;
    localparam logic KIND_BATT = 1'b1;

    // register map: centers at 0..3, spans at 4..7
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_BASE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN_BASE   = 4'd4;

    // register reset values
    localparam logic [CENTER_W-1:0] CENTER_RST [NUM_AXES] =
        '{12'd1455, 12'd1425, 12'd1410, 12'd1415};
    localparam logic [SPAN_W-1:0] SPAN_RST [NUM_AXES] =
        '{-13'sd2456, 13'sd2456, 13'sd2456, -13'sd2456};

    // channel to slot routing
    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } slot_map_t;

    // divider handshake
    typedef struct packed {
        logic              start;
        logic [QCNT_W-1:0] qbits;
    } div_ctrl_t;

    typedef struct packed {
        logic done;
        logic ovf;
    } div_stat_t;

    function automatic slot_map_t chan_slot(input logic [CHAN_W-1:0] ch);
        slot_map_t m;
        m.hit  = 1'b1;
        m.slot = '0;
        unique case (ch)
            3'd0:    m.slot = 3'd1;
            3'd1:    m.slot = 3'd0;
            3'd2:    m.slot = 3'd3;
            3'd3:    m.slot = 3'd2;
            3'd4:    m.slot = BATT_SLOT;
            default: m.hit  = 1'b0;
        endcase
        return m;
    endfunction

endpackage

/* src/acar_div.sv */
// restoring divider, one quotient bit per cycle, with an overflow check up front
// depends on acar_pkg

module acar_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  acar_pkg::div_ctrl_t        ctrl,
    input  logic [acar_pkg::NUM_W-1:0] num,
    input  logic [acar_pkg::DEN_W-1:0] den,
    output acar_pkg::div_stat_t        stat,
    output logic [acar_pkg::Q_W-1:0]   quo
);
    import acar_pkg::*;

    logic [NUM_W-1:0]  rem_reg, rem_next;
    logic [DVS_W-1:0]  dvs_reg, dvs_next;
    logic [Q_W-1:0]    quo_reg, quo_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              first_reg, first_next;
    logic              done_reg, done_next;
    logic              ovf_reg, ovf_next;
    logic              ge;

    // remainder against shifted divisor
    assign ge = CMP_W'(rem_reg) >= CMP_W'(dvs_reg);

    // step logic
    always_comb
    begin
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        first_next = first_reg;
        ovf_next   = ovf_reg;
        done_next  = 1'b0;
        if (ctrl.start)
        begin
            rem_next   = num;
            dvs_next   = DVS_W'(den) << ctrl.qbits;
            quo_next   = '0;
            cnt_next   = ctrl.qbits;
            busy_next  = 1'b1;
            first_next = 1'b1;
            ovf_next   = 1'b0;
        end
        else if (busy_reg)
        begin
            if (first_reg)
            begin
                // quotient would not fit in qbits
                first_next = 1'b0;
                if (ge)
                begin
                    ovf_next  = 1'b1;
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
                else
                begin
                    dvs_next = dvs_reg >> 1;
                end
            end
            else
            begin
                if (ge)
                begin
                    rem_next = rem_reg - dvs_reg[NUM_W-1:0];
                end
                quo_next = {quo_reg[Q_W-2:0], ge};
                dvs_next = dvs_reg >> 1;
                cnt_next = cnt_reg - QCNT_W'(1);
                if (cnt_reg == QCNT_W'(1))
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            first_reg <= 1'b0;
            done_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            first_reg <= first_next;
            done_reg  <= done_next;
            ovf_reg   <= ovf_next;
            cnt_reg   <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign stat.done = done_reg;
    assign stat.ovf  = ovf_reg;
    assign quo       = quo_reg;

endmodule

/* src/adc_channel_average_ratio.sv */
// per-slot adc averager with joystick ratio and battery millivolt readouts
// depends on acar_pkg and acar_div
//
// a sample beat is taken while idle and the block is ready again the next cycle
// a joystick readout gives four beats, each made with one shared multiplier over three
// passes, then the shared divider at one quotient bit per cycle; output stalls hold each beat
// a battery readout gives one beat, from a 13-bit divide
// an empty slot or zero span skips the divider; input is not ready during a readout
// reset clears all slot sums and counts and loads the default centers and spans

module adc_channel_average_ratio (
    input  logic                               clk,
    input  logic                               rst_n,
    // input stream: tdata = adc_channel, sample_value, zero pad; tuser = op
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [acar_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input  logic [acar_pkg::OP_W-1:0]          s_axis_tuser,
    // output stream: tdata = axis, ratio, millivolts, zero pad; tuser = kind
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [acar_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic                               m_axis_tuser,
    output logic                               m_axis_tlast,
    // register writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [acar_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [acar_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import acar_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_DSTART,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [CENTER_W-1:0] center_reg [NUM_AXES];
    logic [SPAN_W-1:0]   span_reg   [NUM_AXES];

    // slot storage
    logic [SUM_W-1:0]      slot_sum_reg   [NUM_SLOTS];
    logic [COUNT_BITS-1:0] slot_count_reg [NUM_SLOTS];

    // sequencer working registers
    logic                     kind_reg, kind_next;
    logic [AXIS_W-1:0]        axis_reg, axis_next;
    logic [SUM_W-1:0]         sum_reg, sum_next;
    logic [COUNT_BITS-1:0]    cnt_reg, cnt_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [MULA_W-1:0] diff_reg, diff_next;
    logic signed [PROD_W-1:0] num_reg, num_next;
    logic signed [PROD_W-1:0] den_reg, den_next;
    logic                     neg_reg, neg_next;

    // output registers
    logic                out_valid_reg, out_valid_next;
    logic                out_kind_reg, out_kind_next;
    logic [AXIS_W-1:0]   out_axis_reg, out_axis_next;
    logic [RATIO_W-1:0]  out_ratio_reg, out_ratio_next;
    logic [MV_W-1:0]     out_mv_reg, out_mv_next;
    logic                out_last_reg, out_last_next;

    // input beat fields
    logic [CHAN_W-1:0]      in_chan;
    logic [SAMPLE_BITS-1:0] in_sample;
    logic                   in_accept;
    slot_map_t              in_map;

    // slot access
    logic [SLOT_W-1:0]     slot_addr;
    logic [SUM_W-1:0]      slot_rd_sum;
    logic [COUNT_BITS-1:0] slot_rd_count;
    logic                  smp_wr;
    logic                  slot_clr;

    // shared multiplier
    logic signed [MULA_W-1:0] mul_a;
    logic signed [MULB_W-1:0] mul_b;
    logic signed [PROD_W-1:0] mul_p;

    // divider hookup
    div_ctrl_t          div_ctrl;
    div_stat_t          div_stat;
    logic [NUM_W-1:0]   div_num;
    logic [DEN_W-1:0]   div_den;
    logic [Q_W-1:0]     div_quo;
    logic [PROD_W-1:0]  num_abs;
    logic [PROD_W-1:0]  den_abs;
    logic [RATIO_W-2:0] ratio_mag;

    assign in_chan   = s_axis_tdata[CHAN_W-1:0];
    assign in_sample = s_axis_tdata[CHAN_W +: SAMPLE_BITS];
    assign in_map    = chan_slot(in_chan);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                center_reg[i] <= CENTER_RST[i];
                span_reg[i]   <= SPAN_RST[i];
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index[CFG_IDX_W-1:2] == CFG_CENTER_BASE[CFG_IDX_W-1:2])
            begin
                center_reg[cfg_index[1:0]] <= cfg_data[CENTER_W-1:0];
            end
            else if (cfg_index[CFG_IDX_W-1:2] == CFG_SPAN_BASE[CFG_IDX_W-1:2])
            begin
                span_reg[cfg_index[1:0]] <= cfg_data[SPAN_W-1:0];
            end
        end
    end

    // one slot port: sample accumulate when idle, readout load and clear otherwise
    assign slot_addr     = (state_reg == ST_IDLE) ? in_map.slot :
                           (kind_reg == KIND_BATT) ? BATT_SLOT : SLOT_W'(axis_reg);
    assign slot_rd_sum   = slot_sum_reg[slot_addr];
    assign slot_rd_count = slot_count_reg[slot_addr];
    assign smp_wr        = in_accept && (s_axis_tuser == OP_SAMPLE) && in_map.hit &&
                           (slot_rd_count != COUNT_MAX);
    assign slot_clr      = (state_reg == ST_LOAD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                slot_sum_reg[i]   <= '0;
                slot_count_reg[i] <= '0;
            end
        end
        else if (smp_wr)
        begin
            slot_sum_reg[slot_addr]   <= slot_rd_sum + SUM_W'(in_sample);
            slot_count_reg[slot_addr] <= slot_rd_count + COUNT_BITS'(1);
        end
        else if (slot_clr)
        begin
            slot_sum_reg[slot_addr]   <= '0;
            slot_count_reg[slot_addr] <= '0;
        end
    end

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MUL1:
            begin
                if (kind_reg == KIND_BATT)
                begin
                    mul_a = MULA_W'(sum_reg);
                    mul_b = MULB_W'(MV_SCALE);
                end
                else
                begin
                    mul_a = MULA_W'(center_reg[axis_reg]);
                    mul_b = MULB_W'(cnt_reg);
                end
            end
            ST_MUL2:
            begin
                if (kind_reg == KIND_BATT)
                begin
                    mul_a = MULA_W'(cnt_reg);
                    mul_b = MULB_W'(BATT_DIV);
                end
                else
                begin
                    mul_a = MULA_W'($signed(span_reg[axis_reg]));
                    mul_b = MULB_W'(cnt_reg);
                end
            end
            ST_MUL3:
            begin
                mul_a = diff_reg;
                mul_b = MULB_W'(RATIO_SCALE);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // magnitudes into the divider
    assign num_abs        = num_reg[PROD_W-1] ? PROD_W'(-num_reg) : PROD_W'(num_reg);
    assign den_abs        = den_reg[PROD_W-1] ? PROD_W'(-den_reg) : PROD_W'(den_reg);
    assign div_num        = num_abs[NUM_W-1:0];
    assign div_den        = den_abs[DEN_W-1:0];
    assign div_ctrl.start = (state_reg == ST_DSTART) && (den_reg != '0);
    assign div_ctrl.qbits = (kind_reg == KIND_BATT) ? BATT_QBITS : JOY_QBITS;

    acar_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (div_ctrl),
        .num   (div_num),
        .den   (div_den),
        .stat  (div_stat),
        .quo   (div_quo)
    );

    // clamp of the joystick quotient
    always_comb
    begin
        if (div_stat.ovf || (div_quo[RATIO_W-2:0] > RATIO_MAX) ||
            (div_quo[Q_W-1:RATIO_W-1] != '0))
        begin
            ratio_mag = RATIO_MAX;
        end
        else
        begin
            ratio_mag = div_quo[RATIO_W-2:0];
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        axis_next      = axis_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        prod_next      = prod_reg;
        diff_next      = diff_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_axis_next  = out_axis_reg;
        out_ratio_next = out_ratio_reg;
        out_mv_next    = out_mv_reg;
        out_last_next  = out_last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (s_axis_tuser == OP_JOY)
                    begin
                        kind_next  = KIND_JOY;
                        axis_next  = '0;
                        state_next = ST_LOAD;
                    end
                    else if (s_axis_tuser == OP_BATT)
                    begin
                        kind_next  = KIND_BATT;
                        axis_next  = '0;
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD:
            begin
                sum_next   = slot_rd_sum;
                cnt_next   = slot_rd_count;
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                if (kind_reg == KIND_BATT)
                begin
                    num_next = mul_p;
                end
                else
                begin
                    prod_next = mul_p;
                end
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                den_next = mul_p;
                if (kind_reg == KIND_BATT)
                begin
                    state_next = ST_DSTART;
                end
                else
                begin
                    diff_next  = MULA_W'(sum_reg) - prod_reg[MULA_W-1:0];
                    state_next = ST_MUL3;
                end
            end
            ST_MUL3:
            begin
                num_next   = mul_p;
                state_next = ST_DSTART;
            end
            ST_DSTART:
            begin
                neg_next = num_reg[PROD_W-1] ^ den_reg[PROD_W-1];
                if (den_reg == '0)
                begin
                    // empty slot or zero span
                    out_valid_next = 1'b1;
                    out_kind_next  = kind_reg;
                    out_axis_next  = axis_reg;
                    out_ratio_next = '0;
                    out_mv_next    = '0;
                    out_last_next  = (kind_reg == KIND_BATT) ||
                                     (axis_reg == AXIS_W'(NUM_AXES - 1));
                    state_next     = ST_OUT;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = kind_reg;
                    out_axis_next  = axis_reg;
                    out_last_next  = (kind_reg == KIND_BATT) ||
                                     (axis_reg == AXIS_W'(NUM_AXES - 1));
                    if (kind_reg == KIND_BATT)
                    begin
                        out_ratio_next = '0;
                        out_mv_next    = div_stat.ovf ? MV_MAX : div_quo[MV_W-1:0];
                    end
                    else
                    begin
                        out_ratio_next = neg_reg ? RATIO_W'(-{1'b0, ratio_mag}) :
                                                   {1'b0, ratio_mag};
                        out_mv_next    = '0;
                    end
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (m_axis_tready)
                begin
                    out_valid_next = 1'b0;
                    if (out_last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        axis_next  = axis_reg + AXIS_W'(1);
                        state_next = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            kind_reg      <= KIND_JOY;
            axis_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_kind_reg  <= KIND_JOY;
            out_axis_reg  <= '0;
            out_ratio_reg <= '0;
            out_mv_reg    <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
            out_kind_reg  <= out_kind_next;
            out_axis_reg  <= out_axis_next;
            out_ratio_reg <= out_ratio_next;
            out_mv_reg    <= out_mv_next;
            out_last_reg  <= out_last_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        sum_reg  <= sum_next;
        cnt_reg  <= cnt_next;
        prod_reg <= prod_next;
        diff_reg <= diff_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        neg_reg  <= neg_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = OUT_TDATA_W'({out_mv_reg, out_ratio_reg, out_axis_reg});

    // no input beat while a result is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while result pending");

    // last marks the battery beat or the final axis
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |->
            (m_axis_tuser == KIND_BATT || out_axis_reg == AXIS_W'(NUM_AXES - 1)))
        else $error("last on a non-final beat");

    // ratio stays within the clamp
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_JOY) |->
            ($signed(out_ratio_reg) <= 8'sd100 && $signed(out_ratio_reg) >= -8'sd100))
        else $error("ratio outside clamp");

    // unused fields are zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == KIND_BATT) ?
            (out_axis_reg == '0 && out_ratio_reg == '0) : (out_mv_reg == '0))
        else $error("unused result field not zero");

    // ready again once the final beat of a readout is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("not ready after readout");

endmodule
